FILE: rtl/modbus_rtu_response_deframer_top_macros.svh
// Assertion macros shared by the Modbus RTU response deframer RTL.
// Each macro expects a clock named clk and an active high reset named rst in scope.
`ifndef MODBUS_RTU_RESPONSE_DEFRAMER_TOP_MACROS_SVH
`define MODBUS_RTU_RESPONSE_DEFRAMER_TOP_MACROS_SVH

// Checks an implication that must hold in the same cycle.
`define MRRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks an implication whose consequence must hold in the next cycle.
`define MRRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mrrd_pkg.sv
// Types, constants and the CRC-16 byte update for the Modbus RTU response deframer.
// Has no dependencies; the interfaces, the frame core and the top level import it.
package mrrd_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;

  localparam logic [BYTE_W-1:0] FUNC_CODE = 8'h04;
  localparam logic [WORD_W-1:0] CRC_INIT  = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY  = 16'hA001;

  typedef struct packed {
    logic              crc_ok;
    logic [WORD_W-1:0] data_word;
  } mrrd_result_t;

  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] crc;
    crc = crc_in ^ {{(WORD_W-BYTE_W){1'b0}}, data};
    for (int i = 0; i < BYTE_W; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  localparam logic [WORD_W-1:0] CRC_OF_ZERO = crc_byte(CRC_INIT, 8'h00);

endpackage

FILE: rtl/mrrd_byte_if.sv
// Valid/ready channel interfaces for received bytes and for deframed results.
// Depends on mrrd_pkg for the field widths.
interface mrrd_byte_if import mrrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrrd_result_if import mrrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              crc_ok;
  logic [WORD_W-1:0] data_word;

  modport source (output valid, output crc_ok, output data_word, input ready);
  modport sink (input valid, input crc_ok, input data_word, output ready);
endinterface

FILE: rtl/mrrd_frame_core.sv
// Frame tracking, CRC-16 accumulation and word capture for one byte per step.
// Depends on mrrd_pkg for the CRC byte update and the result type.
module mrrd_frame_core import mrrd_pkg::*; #(
  parameter int FRAME_BYTES = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] slave_address,
  input  logic              step,
  input  logic [BYTE_W-1:0] data,
  output logic              res_valid,
  output mrrd_result_t      res
);

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] START_IDX     = CNT_W'(2);
  localparam logic [CNT_W-1:0] HIGH_IDX      = CNT_W'(3);
  localparam logic [CNT_W-1:0] LOW_IDX       = CNT_W'(4);
  localparam logic [CNT_W-1:0] CRC_LAST_IDX  = CNT_W'(FRAME_BYTES - 3);
  localparam logic [CNT_W-1:0] CRC_LOW_IDX   = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] LAST_IDX      = CNT_W'(FRAME_BYTES - 1);

  logic [BYTE_W-1:0] previous_byte;
  logic [WORD_W-1:0] previous_crc;
  logic              receiving;
  logic [CNT_W-1:0]  byte_count;
  logic [WORD_W-1:0] crc_accumulator;
  logic [WORD_W-1:0] word_capture;
  logic              first_crc_match;

  logic              receiving_next;
  logic [CNT_W-1:0]  byte_count_next;
  logic [WORD_W-1:0] crc_accumulator_next;
  logic [WORD_W-1:0] word_capture_next;
  logic              first_crc_match_next;
  logic              start;

  always_comb begin
    start                = (previous_byte == slave_address) && (data == FUNC_CODE);
    receiving_next       = receiving;
    byte_count_next      = byte_count;
    crc_accumulator_next = crc_accumulator;
    word_capture_next    = word_capture;
    first_crc_match_next = first_crc_match;
    res_valid            = 1'b0;
    if (start) begin
      receiving_next       = 1'b1;
      byte_count_next      = START_IDX;
      crc_accumulator_next = crc_byte(previous_crc, data);
      word_capture_next    = '0;
      first_crc_match_next = 1'b0;
    end else if (receiving) begin
      if (byte_count <= CRC_LAST_IDX) begin
        crc_accumulator_next = crc_byte(crc_accumulator, data);
      end
      if (byte_count == HIGH_IDX) begin
        word_capture_next = {data, word_capture[BYTE_W-1:0]};
      end
      if (byte_count == LOW_IDX) begin
        word_capture_next = {word_capture[WORD_W-1:BYTE_W], data};
      end
      if (byte_count == CRC_LOW_IDX) begin
        first_crc_match_next = (data == crc_accumulator[BYTE_W-1:0]);
      end
      if (byte_count == LAST_IDX) begin
        res_valid       = 1'b1;
        receiving_next  = 1'b0;
        byte_count_next = '0;
      end else begin
        byte_count_next = byte_count + CNT_W'(1);
      end
    end
    res.crc_ok    = first_crc_match && (data == crc_accumulator[WORD_W-1:BYTE_W]);
    res.data_word = word_capture_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte   <= '0;
      previous_crc    <= CRC_OF_ZERO;
      receiving       <= 1'b0;
      byte_count      <= '0;
      crc_accumulator <= CRC_INIT;
      word_capture    <= '0;
      first_crc_match <= 1'b0;
    end else if (step) begin
      previous_byte   <= data;
      previous_crc    <= crc_byte(CRC_INIT, data);
      receiving       <= receiving_next;
      byte_count      <= byte_count_next;
      crc_accumulator <= crc_accumulator_next;
      word_capture    <= word_capture_next;
      first_crc_match <= first_crc_match_next;
    end
  end

endmodule

FILE: rtl/modbus_rtu_response_deframer_top.sv
// The last frame byte is registered at the input, then its result at the output.
// Throughput: one byte per cycle while no result waits on result.ready; the frame
// logic updates its CRC one byte per cycle. An input register and an output register
// let one byte be taken while a result waits. Reset (rst, synchronous, active high)
// clears the frame state, both valid flags and sets the slave address to 1.
`include "modbus_rtu_response_deframer_top_macros.svh"

// Top level of the Modbus RTU response deframer.
// Depends on mrrd_pkg, the channel interfaces and mrrd_frame_core.
module modbus_rtu_response_deframer_top import mrrd_pkg::*; #(
  parameter int FRAME_BYTES = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [BYTE_W-1:0] cfg_write_data,
  mrrd_byte_if.sink         rx,
  mrrd_result_if.source     result
);

  logic [BYTE_W-1:0] slave_address;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  mrrd_result_t      out_res;
  logic              core_valid;
  mrrd_result_t      core_res;
  logic              consume;

  assign consume  = in_valid && (!core_valid || !out_valid || result.ready);
  assign rx.ready = !in_valid || consume;

  assign result.valid     = out_valid;
  assign result.crc_ok    = out_res.crc_ok;
  assign result.data_word = out_res.data_word;

  mrrd_frame_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .slave_address(slave_address),
    .step         (consume),
    .data         (in_byte),
    .res_valid    (core_valid),
    .res          (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        slave_address <= cfg_write_data;
      end
      if (rx.valid && rx.ready) begin
        in_valid <= 1'b1;
      end else if (consume) begin
        in_valid <= 1'b0;
      end
      if (consume && core_valid) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
    if (consume && core_valid) begin
      out_res <= core_res;
    end
  end

  `MRRD_ASSERT_NOW(a_no_overwrite, consume && core_valid,
                   !out_valid || result.ready, "result overwritten before it was taken")
  `MRRD_ASSERT_NEXT(a_held_item, in_valid && !consume && !rx.ready,
                    in_valid && $stable(in_byte), "held item lost")
  `MRRD_ASSERT_NOW(a_ready_when_free, !out_valid, rx.ready,
                   "input stalled with no result waiting")

endmodule
